// ----- hdl/rcc_pkg.sv -----
// ============================================================================
// rcc_pkg
// Shared constants and types for the carry-caching range encoder.
// ============================================================================
package rcc_pkg;

    localparam int RCC_PROB_BITS    = 14;
    localparam int RCC_TOTAL_BITS   = 16;
    localparam int RCC_PENDING_BITS = 32;

    localparam int LOW_BITS   = 33;
    localparam int RANGE_BITS = 32;
    localparam int COUNT_BITS = 32;
    localparam int BYTE_BITS  = 8;

    localparam logic [RANGE_BITS-1:0] TOP_LIMIT   = 32'h0100_0000;
    localparam logic [RANGE_BITS-1:0] CARRY_LIMIT = 32'hFF00_0000;
    localparam logic [RANGE_BITS-1:0] RANGE_INIT  = 32'hFFFF_FFFF;
    localparam logic [BYTE_BITS-1:0]  FILL_NO_CARRY = 8'hFF;
    localparam logic [BYTE_BITS-1:0]  FILL_CARRY    = 8'h00;
    localparam int FLUSH_SHIFTS = 5;

    localparam logic [2:0] REQ_FREQ  = 3'd0;
    localparam logic [2:0] REQ_BIT0  = 3'd1;
    localparam logic [2:0] REQ_BIT1  = 3'd2;
    localparam logic [2:0] REQ_FLUSH = 3'd3;
    localparam logic [2:0] REQ_START = 3'd4;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_DIV   = 10'b00_0000_0010,
        ST_MUL_A = 10'b00_0000_0100,
        ST_MUL_B = 10'b00_0000_1000,
        ST_SET_R = 10'b00_0001_0000,
        ST_MUL_P = 10'b00_0010_0000,
        ST_BIN   = 10'b00_0100_0000,
        ST_NORM  = 10'b00_1000_0000,
        ST_FLUSH = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } rcc_state_t;

endpackage

// ----- hdl/rcc_req_if.sv -----
// ============================================================================
// rcc_req_if
// Request channel: one coding request per transfer.
// ============================================================================
interface rcc_req_if
    import rcc_pkg::*;
#(
    parameter int TOTAL_BITS = RCC_TOTAL_BITS,
    parameter int PROB_BITS  = RCC_PROB_BITS
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            req_type;
    logic [TOTAL_BITS-1:0] sym_start;
    logic [TOTAL_BITS-1:0] sym_size;
    logic [TOTAL_BITS-1:0] freq_total;
    logic [PROB_BITS-1:0]  prob_zero;

    modport source (
        output valid, req_type, sym_start, sym_size, freq_total, prob_zero,
        input  ready
    );

    modport sink (
        input  valid, req_type, sym_start, sym_size, freq_total, prob_zero,
        output ready
    );
endinterface

// ----- hdl/rcc_grp_if.sv -----
// ============================================================================
// rcc_grp_if
// Result channel: one released byte group per transfer.
// ============================================================================
interface rcc_grp_if
    import rcc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BYTE_BITS-1:0]  lead_byte;
    logic [BYTE_BITS-1:0]  fill_byte;
    logic [COUNT_BITS-1:0] fill_count;
    logic                  last;

    modport source (
        output valid, lead_byte, fill_byte, fill_count, last,
        input  ready
    );

    modport sink (
        input  valid, lead_byte, fill_byte, fill_count, last,
        output ready
    );
endinterface

// ----- hdl/range_encoder_carry_cache.sv -----
// ============================================================================
// range_encoder_carry_cache
// Byte-wise range encoder with a carry cache and a shared sequential datapath.
// ============================================================================
// One request is taken at a time; req.ready is high only while the sequencer
// is idle. A frequency symbol passes through a bit-serial restoring division
// of the range by the total, ST_MUL_A and ST_MUL_B through the shared 32x16
// multiplier, ST_SET_R to set the range, one step per renormalisation byte
// shift (up to three) plus one to see the range settle, and one to close the
// request. A binary symbol needs at most two shifts, a flush FLUSH_SHIFTS
// shifts, and a start or unknown request is handled when it is taken. Each
// released byte group is staged in a hold register until the next one, or
// the end of the request, shows whether it is the last; the output register
// lets a new request start while the final group still waits. A full output
// register stalls the sequencer.
// ============================================================================
module range_encoder_carry_cache
    import rcc_pkg::*;
#(
    parameter int PROB_BITS    = RCC_PROB_BITS,
    parameter int TOTAL_BITS   = RCC_TOTAL_BITS,
    parameter int PENDING_BITS = RCC_PENDING_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    rcc_req_if.sink    req,
    rcc_grp_if.source  grp
);

    localparam int MUL_B_BITS = (TOTAL_BITS > PROB_BITS) ? TOTAL_BITS : PROB_BITS;
    localparam int MUL_BITS   = RANGE_BITS + MUL_B_BITS;

    rcc_state_t                state_reg, state_next;
    logic [2:0]                kind_reg, kind_next;
    logic [TOTAL_BITS-1:0]     start_reg, start_next;
    logic [TOTAL_BITS-1:0]     size_reg, size_next;
    logic [TOTAL_BITS-1:0]     total_reg, total_next;
    logic [PROB_BITS-1:0]      p0_reg, p0_next;
    logic [LOW_BITS-1:0]       low_reg, low_next;
    logic [RANGE_BITS-1:0]     range_reg, range_next;
    logic [BYTE_BITS-1:0]      cache_reg, cache_next;
    logic [PENDING_BITS-1:0]   pend_reg, pend_next;
    logic [TOTAL_BITS-1:0]     rem_reg, rem_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic [RANGE_BITS-1:0]     prod_reg, prod_next;
    logic                      hold_valid_reg, hold_valid_next;
    logic [BYTE_BITS-1:0]      hold_lead_reg, hold_lead_next;
    logic [BYTE_BITS-1:0]      hold_fill_reg, hold_fill_next;
    logic [COUNT_BITS-1:0]     hold_count_reg, hold_count_next;
    logic                      out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]      out_lead_reg, out_lead_next;
    logic [BYTE_BITS-1:0]      out_fill_reg, out_fill_next;
    logic [COUNT_BITS-1:0]     out_count_reg, out_count_next;
    logic                      out_last_reg, out_last_next;

    logic                          req_fire;
    logic                          out_free;
    logic [RANGE_BITS-1:0]         mul_a;
    logic [MUL_B_BITS-1:0]         mul_b;
    logic [MUL_BITS-1:0]           mul_full;
    logic [LOW_BITS-1:0]           low_add;
    logic [TOTAL_BITS:0]           rem_shift;
    logic                          rem_ge;
    logic [RANGE_BITS-1:0]         low32;
    logic                          carry;
    logic                          emit;
    logic                          shift_ok;
    logic [PENDING_BITS-1:0]       pend_fill;
    logic [PENDING_BITS+COUNT_BITS-1:0] pend_fill_ext;
    logic [BYTE_BITS-1:0]          grp_lead;
    logic [BYTE_BITS-1:0]          grp_fill;
    logic [RANGE_BITS-1:0]         bin_range;

    assign req.ready      = (state_reg == ST_IDLE);
    assign req_fire       = req.valid && req.ready;
    assign out_free       = !out_valid_reg || grp.ready;

    assign grp.valid      = out_valid_reg;
    assign grp.lead_byte  = out_lead_reg;
    assign grp.fill_byte  = out_fill_reg;
    assign grp.fill_count = out_count_reg;
    assign grp.last       = out_last_reg;

    assign mul_a    = (state_reg == ST_MUL_P) ? (range_reg >> PROB_BITS) : range_reg;
    assign mul_full = mul_a * mul_b;
    assign low_add  = low_reg + {1'b0, prod_reg};

    assign rem_shift = {rem_reg, range_reg[RANGE_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, total_reg});

    assign low32         = low_reg[RANGE_BITS-1:0];
    assign carry         = low_reg[LOW_BITS-1];
    assign emit          = (low32 < CARRY_LIMIT) || carry;
    assign shift_ok      = !(emit && hold_valid_reg && !out_free);
    assign pend_fill     = (pend_reg == '0) ? '0 : pend_reg - 1'b1;
    assign pend_fill_ext = {{COUNT_BITS{1'b0}}, pend_fill};
    assign grp_lead      = cache_reg + {{(BYTE_BITS-1){1'b0}}, carry};
    assign grp_fill      = carry ? FILL_CARRY : FILL_NO_CARRY;

    always_comb
    begin
        case (state_reg)
            ST_MUL_A: mul_b = MUL_B_BITS'(start_reg);
            ST_MUL_P: mul_b = MUL_B_BITS'(p0_reg);
            default:  mul_b = MUL_B_BITS'(size_reg);
        endcase
    end

    always_comb
    begin
        bin_range = (kind_reg == REQ_BIT0) ? prod_reg : range_reg - prod_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        start_next      = start_reg;
        size_next       = size_reg;
        total_next      = total_reg;
        p0_next         = p0_reg;
        low_next        = low_reg;
        range_next      = range_reg;
        cache_next      = cache_reg;
        pend_next       = pend_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        hold_valid_next = hold_valid_reg;
        hold_lead_next  = hold_lead_reg;
        hold_fill_next  = hold_fill_reg;
        hold_count_next = hold_count_reg;
        out_valid_next  = out_valid_reg && !grp.ready;
        out_lead_next   = out_lead_reg;
        out_fill_next   = out_fill_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next  = req.req_type;
                    start_next = req.sym_start;
                    size_next  = (req.sym_size == '0) ? TOTAL_BITS'(1) : req.sym_size;
                    total_next = (req.freq_total == '0) ? TOTAL_BITS'(1) : req.freq_total;
                    p0_next    = (req.prob_zero == '0) ? PROB_BITS'(1) : req.prob_zero;
                    case (req.req_type)
                        REQ_FREQ:
                        begin
                            rem_next   = '0;
                            cnt_next   = 5'd31;
                            state_next = ST_DIV;
                        end
                        REQ_BIT0, REQ_BIT1:
                        begin
                            state_next = ST_MUL_P;
                        end
                        REQ_FLUSH:
                        begin
                            cnt_next   = 5'(FLUSH_SHIFTS - 1);
                            state_next = ST_FLUSH;
                        end
                        REQ_START:
                        begin
                            low_next   = '0;
                            range_next = RANGE_INIT;
                            cache_next = '0;
                            pend_next  = PENDING_BITS'(1);
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next   = rem_ge ? TOTAL_BITS'(rem_shift - {1'b0, total_reg})
                                    : rem_shift[TOTAL_BITS-1:0];
                range_next = {range_reg[RANGE_BITS-2:0], rem_ge};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                prod_next  = mul_full[RANGE_BITS-1:0];
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                low_next   = low_add;
                prod_next  = mul_full[RANGE_BITS-1:0];
                state_next = ST_SET_R;
            end
            ST_SET_R:
            begin
                range_next = (prod_reg == '0) ? RANGE_BITS'(1) : prod_reg;
                state_next = ST_NORM;
            end
            ST_MUL_P:
            begin
                prod_next  = mul_full[RANGE_BITS-1:0];
                state_next = ST_BIN;
            end
            ST_BIN:
            begin
                if (kind_reg != REQ_BIT0)
                begin
                    low_next = low_add;
                end
                range_next = (bin_range == '0) ? RANGE_BITS'(1) : bin_range;
                state_next = ST_NORM;
            end
            ST_NORM, ST_FLUSH:
            begin
                if ((state_reg == ST_NORM) && (range_reg >= TOP_LIMIT))
                begin
                    state_next = ST_DONE;
                end
                else if (shift_ok)
                begin
                    if (emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_lead_next  = hold_lead_reg;
                            out_fill_next  = hold_fill_reg;
                            out_count_next = hold_count_reg;
                            out_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_lead_next  = grp_lead;
                        hold_fill_next  = grp_fill;
                        hold_count_next = pend_fill_ext[COUNT_BITS-1:0];
                        cache_next      = low32[RANGE_BITS-1 -: BYTE_BITS];
                        pend_next       = PENDING_BITS'(1);
                    end
                    else if (pend_reg != '1)
                    begin
                        pend_next = pend_reg + 1'b1;
                    end
                    low_next = {1'b0, low32[RANGE_BITS-BYTE_BITS-1:0], {BYTE_BITS{1'b0}}};
                    if (state_reg == ST_NORM)
                    begin
                        range_next = {range_reg[RANGE_BITS-BYTE_BITS-1:0],
                                      {BYTE_BITS{1'b0}}};
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 5'd1;
                        if (cnt_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_lead_next   = hold_lead_reg;
                    out_fill_next   = hold_fill_reg;
                    out_count_next  = hold_count_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= '0;
            range_reg      <= RANGE_INIT;
            cache_reg      <= '0;
            pend_reg       <= PENDING_BITS'(1);
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            range_reg      <= range_next;
            cache_reg      <= cache_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        start_reg      <= start_next;
        size_reg       <= size_next;
        total_reg      <= total_next;
        p0_reg         <= p0_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        prod_reg       <= prod_next;
        hold_lead_reg  <= hold_lead_next;
        hold_fill_reg  <= hold_fill_next;
        hold_count_reg <= hold_count_next;
        out_lead_reg   <= out_lead_next;
        out_fill_reg   <= out_fill_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

`ifndef ASSERT_OFF
    a_idle_range_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (range_reg >= TOP_LIMIT))
        else $error("range below renormalisation limit while idle");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held group left behind at end of request");

    a_idle_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pend_reg != '0))
        else $error("pending count zero while idle");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < total_reg))
        else $error("division remainder not below divisor");
`endif

endmodule
